/* rtl/hrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_pkg
// Types and constants shared by the homography event remapper.
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 32;
  localparam int HW_BITS    = 48;
  localparam int NUM_REGS   = 8;
  localparam int IDX_BITS   = 3;
  localparam int Q_BITS     = 16;
  localparam int ACC_BITS   = 64;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_H00 = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_H01 = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_H02 = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_H10 = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_H11 = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_H12 = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_H20 = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_H21 = 3'd7;

  localparam logic signed [HW_BITS-1:0] RST_H00 = 48'sd2111646361;
  localparam logic signed [HW_BITS-1:0] RST_H01 = 48'sd625247807;
  localparam logic signed [HW_BITS-1:0] RST_H02 = 48'sd647626401818;
  localparam logic signed [HW_BITS-1:0] RST_H10 = -48'sd990049350;
  localparam logic signed [HW_BITS-1:0] RST_H11 = 48'sd4093092855;
  localparam logic signed [HW_BITS-1:0] RST_H12 = 48'sd53296661930;
  localparam logic signed [HW_BITS-1:0] RST_H20 = -48'sd7619639;
  localparam logic signed [HW_BITS-1:0] RST_H21 = 48'sd1381501;

  typedef struct packed {
    logic        side;
    logic [9:0]  event_x;
    logic [9:0]  event_y;
    logic [63:0] event_time;
    logic        event_polarity;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [63:0] out_time;
    logic        out_polarity;
    logic        out_of_range;
  } out_item_t;

endpackage

/* rtl/homography_event_remap_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_event_remap_core
// Pipelined homography remap of right-sensor events; left events pass.
// ----------------------------------------------------------------------------
// Stages: 19 register stages (multiply, sum, classify, then 16 restoring-
// division stages, one quotient bit each).
// Throughput: one item per cycle; each stage holds only while its successor
// is full and stalled, so gaps collapse under output back-pressure.
// Reset: synchronous, clears all valid bits and loads default homography.
module homography_event_remap_core
  import hrm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [HW_BITS-1:0]  cfg_data
);

  localparam int NST = Q_BITS + 3;
  localparam int CMP_BITS = ACC_BITS + Q_BITS;

  typedef struct packed {
    logic        side;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [63:0] tstamp;
    logic        pol;
  } meta_t;

  typedef struct packed {
    meta_t                       m;
    logic signed [ACC_BITS-1:0]  p0, p1, p3, p4, p6, p7, c2, c5;
  } prod_t;

  typedef struct packed {
    meta_t                m;
    logic [ACC_BITS-1:0]  nx, ny, den;
  } sum_t;

  typedef struct packed {
    meta_t                m;
    logic                 oor;
    logic [ACC_BITS-1:0]  den;
    logic [ACC_BITS-1:0]  rx, ry;
    logic [Q_BITS-1:0]    qx, qy;
  } div_t;

  logic signed [HW_BITS-1:0] h [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      h[REG_H00] <= RST_H00;
      h[REG_H01] <= RST_H01;
      h[REG_H02] <= RST_H02;
      h[REG_H10] <= RST_H10;
      h[REG_H11] <= RST_H11;
      h[REG_H12] <= RST_H12;
      h[REG_H20] <= RST_H20;
      h[REG_H21] <= RST_H21;
    end else if (cfg_we) begin
      h[cfg_index] <= cfg_data;
    end
  end

  logic v   [NST];
  logic rdy [NST+1];

  // ready ripples back from the output, last stage first
  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v[i] || rdy[i+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) v[i] <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) if (rdy[i]) v[i] <= v[i-1];
    end
  end

  // stage 0: products
  prod_t sp;
  meta_t in_m;
  logic signed [COORD_BITS:0] xs, ys;

  assign in_m.side   = in_item.side;
  assign in_m.x      = in_item.event_x[COORD_BITS-1:0];
  assign in_m.y      = in_item.event_y[COORD_BITS-1:0];
  assign in_m.tstamp = in_item.event_time;
  assign in_m.pol    = in_item.event_polarity;
  assign xs = $signed({1'b0, in_m.x});
  assign ys = $signed({1'b0, in_m.y});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sp.m  <= in_m;
      sp.p0 <= h[REG_H00] * xs;
      sp.p1 <= h[REG_H01] * ys;
      sp.p3 <= h[REG_H10] * xs;
      sp.p4 <= h[REG_H11] * ys;
      sp.p6 <= h[REG_H20] * xs;
      sp.p7 <= h[REG_H21] * ys;
      sp.c2 <= ACC_BITS'(h[REG_H02]);
      sp.c5 <= ACC_BITS'(h[REG_H12]);
    end
  end

  // stage 1: numerators and denominator, modulo 2^64
  sum_t ss;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ss.m   <= sp.m;
      ss.nx  <= sp.p0 + sp.p1 + sp.c2;
      ss.ny  <= sp.p3 + sp.p4 + sp.c5;
      ss.den <= sp.p6 + sp.p7 + (ACC_BITS'(1) << FRAC_BITS);
    end
  end

  // stage 2: range screen; a non-negative quotient fits 16 bits iff num < den << 16
  logic                den_bad, bad_x, bad_y;
  logic [ACC_BITS-1:0] mag_x, mag_y;
  logic [CMP_BITS-1:0] den_top;

  assign den_bad = ss.den[ACC_BITS-1] || (ss.den == '0);
  assign mag_x   = -ss.nx;
  assign mag_y   = -ss.ny;
  assign den_top = {ss.den, {Q_BITS{1'b0}}};
  assign bad_x = ss.nx[ACC_BITS-1] ? (mag_x >= ss.den)
                                   : ({{Q_BITS{1'b0}}, ss.nx} >= den_top);
  assign bad_y = ss.ny[ACC_BITS-1] ? (mag_y >= ss.den)
                                   : ({{Q_BITS{1'b0}}, ss.ny} >= den_top);

  div_t sd [Q_BITS+1];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sd[0].m   <= ss.m;
      sd[0].oor <= ss.m.side && (den_bad || bad_x || bad_y);
      sd[0].den <= ss.den;
      sd[0].rx  <= ss.nx[ACC_BITS-1] ? '0 : ss.nx;
      sd[0].ry  <= ss.ny[ACC_BITS-1] ? '0 : ss.ny;
      sd[0].qx  <= '0;
      sd[0].qy  <= '0;
    end
  end

  // restoring division, most significant quotient bit first
  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    localparam int B = Q_BITS - 1 - k;
    logic [CMP_BITS-1:0] dsh;
    logic                tx, ty;

    assign dsh = {{Q_BITS{1'b0}}, sd[k].den} << B;
    assign tx  = {{Q_BITS{1'b0}}, sd[k].rx} >= dsh;
    assign ty  = {{Q_BITS{1'b0}}, sd[k].ry} >= dsh;

    always_ff @(posedge clk) begin
      if (rdy[k+3]) begin
        sd[k+1].m   <= sd[k].m;
        sd[k+1].oor <= sd[k].oor;
        sd[k+1].den <= sd[k].den;
        sd[k+1].rx  <= tx ? sd[k].rx - dsh[ACC_BITS-1:0] : sd[k].rx;
        sd[k+1].ry  <= ty ? sd[k].ry - dsh[ACC_BITS-1:0] : sd[k].ry;
        sd[k+1].qx  <= sd[k].qx | (Q_BITS'(tx) << B);
        sd[k+1].qy  <= sd[k].qy | (Q_BITS'(ty) << B);
      end
    end
  end

  div_t last;
  assign last = sd[Q_BITS];

  assign out_valid = v[NST-1];
  always_comb begin
    out_item.out_time     = last.m.tstamp;
    out_item.out_polarity = last.m.pol;
    out_item.out_of_range = last.oor;
    if (!last.m.side) begin
      out_item.out_x = Q_BITS'(last.m.x);
      out_item.out_y = Q_BITS'(last.m.y);
    end else if (last.oor) begin
      out_item.out_x = '0;
      out_item.out_y = '0;
    end else begin
      out_item.out_x = last.qx;
      out_item.out_y = last.qy;
    end
  end

`ifndef ASSERT_OFF
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted item missing from first stage");
  a_left_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last.m.side |-> !out_item.out_of_range)
    else $error("left item flagged out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled item changed");
`endif

endmodule
